/* hw/rtl/dic_pkg.sv */
package dic_pkg;

    // Two-bit signed sign codes used on the result ports.
    typedef logic signed [1:0] sign_t;

    localparam sign_t SIGN_ZERO = 2'sb00;
    localparam sign_t SIGN_POS  = 2'sb01;
    localparam sign_t SIGN_NEG  = 2'sb11;

    // Load enables for the two register stages inside a lifted-term multiplier.
    typedef struct packed {
        logic part_en;
        logic sum_en;
    } dic_mul_ctl_t;

    function automatic sign_t sign_code(input logic neg, input logic zero);
        sign_t s;
        if (zero)
        begin
            s = SIGN_ZERO;
        end
        else if (neg)
        begin
            s = SIGN_NEG;
        end
        else
        begin
            s = SIGN_POS;
        end
        return s;
    endfunction

endpackage

/* hw/rtl/dic_term_mul.sv */
module dic_term_mul #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                              clk,
    input  dic_pkg::dic_mul_ctl_t             ctl,
    input  logic [2*COORD_WIDTH+1:0]          lift,
    input  logic signed [2*COORD_WIDTH+2:0]   minor,
    output logic signed [4*COORD_WIDTH+5:0]   term
);
    import dic_pkg::*;

    localparam int W       = COORD_WIDTH;
    localparam int H       = W + 1;
    localparam int LIFT_W  = 2 * W + 2;
    localparam int MINOR_W = 2 * W + 3;
    localparam int PX_W    = 2 * W + 4;
    localparam int MID_W   = 2 * W + 6;
    localparam int TERM_W  = 4 * W + 6;

    logic [H-1:0]               lift_lo;
    logic [LIFT_W-H-1:0]        lift_hi;
    logic [H-1:0]               minor_lo;
    logic signed [MINOR_W-H-1:0] minor_hi;

    logic [2*H-1:0]             ll_reg, ll_next;
    logic [2*H-1:0]             hl_reg, hl_next;
    logic signed [PX_W-1:0]     lh_reg, lh_next;
    logic signed [PX_W-1:0]     hh_reg, hh_next;

    logic signed [MID_W-1:0]    mid;
    logic signed [TERM_W-1:0]   cat;
    logic signed [TERM_W-1:0]   term_reg, term_next;

    // The lift is non-negative; the minor is split into an unsigned low half
    // and a signed high half, so four narrow products make up the whole.
    assign lift_lo  = lift[H-1:0];
    assign lift_hi  = lift[LIFT_W-1:H];
    assign minor_lo = minor[H-1:0];
    assign minor_hi = minor[MINOR_W-1:H];

    always_comb
    begin
        ll_next = lift_lo * minor_lo;
        hl_next = lift_hi * minor_lo;
        lh_next = PX_W'($signed({1'b0, lift_lo})) * PX_W'(minor_hi);
        hh_next = PX_W'($signed({1'b0, lift_hi})) * PX_W'(minor_hi);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.part_en)
        begin
            ll_reg <= ll_next;
            hl_reg <= hl_next;
            lh_reg <= lh_next;
            hh_reg <= hh_next;
        end
    end

    // The high-high and low-low products do not overlap, so they are simply
    // placed side by side; only the two cross products need adding in.
    always_comb
    begin
        mid       = MID_W'(lh_reg) + MID_W'($signed({1'b0, hl_reg}));
        cat       = $signed({hh_reg, ll_reg});
        term_next = cat + (TERM_W'(mid) <<< H);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sum_en)
        begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

/* hw/rtl/delaunay_incircle_legality_test.sv */
// An accepted input beat moves through stages 1 to 7 to the result beat.
// Throughput: one beat per cycle while the output side is not stalled;
// each of the seven stages holds one item and a stalled stage is filled
// by the one behind it as soon as it empties.
// Reset clears every stage valid bit; the data registers are not reset.
module delaunay_incircle_legality_test #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] opp_x,
    input  logic signed [COORD_WIDTH-1:0] opp_y,
    input  logic signed [COORD_WIDTH-1:0] next_x,
    input  logic signed [COORD_WIDTH-1:0] next_y,
    input  logic signed [COORD_WIDTH-1:0] prev_x,
    input  logic signed [COORD_WIDTH-1:0] prev_y,
    input  logic signed [COORD_WIDTH-1:0] query_x,
    input  logic signed [COORD_WIDTH-1:0] query_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          edge_legal,
    output dic_pkg::sign_t                orient_sign,
    output dic_pkg::sign_t                incircle_sign
);
    import dic_pkg::*;

    localparam int W       = COORD_WIDTH;
    localparam int DIFF_W  = W + 1;
    localparam int SQ_W    = 2 * W + 2;
    localparam int LIFT_W  = 2 * W + 2;
    localparam int MINOR_W = 2 * W + 3;
    localparam int TERM_W  = 4 * W + 6;
    localparam int DET_W   = 4 * W + 8;
    localparam int STAGES  = 7;

    // Stage valid bits and load enables; stage k takes from stage k-1.
    logic [STAGES:1] vld_reg, vld_next;
    logic [STAGES:1] adv;

    always_comb
    begin
        adv[STAGES] = !vld_reg[STAGES] || out_ready;
        for (int k = STAGES - 1; k >= 1; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (adv[1])
        begin
            vld_next[1] = in_valid;
        end
        for (int k = 2; k <= STAGES; k++)
        begin
            if (adv[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready = adv[1];

    // Stage 1: corners relative to the query point, and the edge vectors
    // for the orientation test.
    logic signed [DIFF_W-1:0] a_reg, b_reg, d_reg, e_reg, g_reg, h_reg;
    logic signed [DIFF_W-1:0] ox1_reg, oy1_reg, ox2_reg, oy2_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            a_reg   <= DIFF_W'(next_x) - DIFF_W'(query_x);
            b_reg   <= DIFF_W'(next_y) - DIFF_W'(query_y);
            d_reg   <= DIFF_W'(opp_x)  - DIFF_W'(query_x);
            e_reg   <= DIFF_W'(opp_y)  - DIFF_W'(query_y);
            g_reg   <= DIFF_W'(prev_x) - DIFF_W'(query_x);
            h_reg   <= DIFF_W'(prev_y) - DIFF_W'(query_y);
            ox1_reg <= DIFF_W'(opp_x)  - DIFF_W'(next_x);
            oy1_reg <= DIFF_W'(opp_y)  - DIFF_W'(next_y);
            ox2_reg <= DIFF_W'(prev_x) - DIFF_W'(next_x);
            oy2_reg <= DIFF_W'(prev_y) - DIFF_W'(next_y);
        end
    end

    // Stage 2: the squares of the differences and the cross products that the minors and the orientation need.
    logic signed [SQ_W-1:0] aa_reg, bb_reg, dd_reg, ee_reg, gg_reg, hh_reg;
    logic signed [SQ_W-1:0] dh_reg, eg_reg, bg_reg, ah_reg, ae_reg, bd_reg;
    logic signed [SQ_W-1:0] o1_reg, o2_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            aa_reg <= SQ_W'(a_reg) * SQ_W'(a_reg);
            bb_reg <= SQ_W'(b_reg) * SQ_W'(b_reg);
            dd_reg <= SQ_W'(d_reg) * SQ_W'(d_reg);
            ee_reg <= SQ_W'(e_reg) * SQ_W'(e_reg);
            gg_reg <= SQ_W'(g_reg) * SQ_W'(g_reg);
            hh_reg <= SQ_W'(h_reg) * SQ_W'(h_reg);
            dh_reg <= SQ_W'(d_reg) * SQ_W'(h_reg);
            eg_reg <= SQ_W'(e_reg) * SQ_W'(g_reg);
            bg_reg <= SQ_W'(b_reg) * SQ_W'(g_reg);
            ah_reg <= SQ_W'(a_reg) * SQ_W'(h_reg);
            ae_reg <= SQ_W'(a_reg) * SQ_W'(e_reg);
            bd_reg <= SQ_W'(b_reg) * SQ_W'(d_reg);
            o1_reg <= SQ_W'(ox1_reg) * SQ_W'(oy2_reg);
            o2_reg <= SQ_W'(oy1_reg) * SQ_W'(ox2_reg);
        end
    end

    // Stage 3: lifted values, the 2x2 minors along the lifted column (the
    // middle one already negated) and the orientation sign.
    logic [LIFT_W-1:0]         lift_c_reg, lift_f_reg, lift_i_reg;
    logic signed [MINOR_W-1:0] m1_reg, nm2_reg, m3_reg;
    logic signed [MINOR_W-1:0] orient_cross;
    sign_t                     os3_reg, os4_reg, os5_reg, os6_reg;

    assign orient_cross = MINOR_W'(o1_reg) - MINOR_W'(o2_reg);

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            lift_c_reg <= aa_reg + bb_reg;
            lift_f_reg <= dd_reg + ee_reg;
            lift_i_reg <= gg_reg + hh_reg;
            m1_reg     <= MINOR_W'(dh_reg) - MINOR_W'(eg_reg);
            nm2_reg    <= MINOR_W'(bg_reg) - MINOR_W'(ah_reg);
            m3_reg     <= MINOR_W'(ae_reg) - MINOR_W'(bd_reg);
            os3_reg    <= sign_code(orient_cross[MINOR_W-1], orient_cross == '0);
        end
    end

    // Stages 4 and 5: the three lifted terms, each in its own multiplier.
    dic_mul_ctl_t             mul_ctl;
    logic signed [TERM_W-1:0] term_c, term_f, term_i;

    assign mul_ctl.part_en = adv[4];
    assign mul_ctl.sum_en  = adv[5];

    dic_term_mul #(.COORD_WIDTH(COORD_WIDTH)) u_term_c (
        .clk   (clk),
        .ctl   (mul_ctl),
        .lift  (lift_c_reg),
        .minor (m1_reg),
        .term  (term_c)
    );

    dic_term_mul #(.COORD_WIDTH(COORD_WIDTH)) u_term_f (
        .clk   (clk),
        .ctl   (mul_ctl),
        .lift  (lift_f_reg),
        .minor (nm2_reg),
        .term  (term_f)
    );

    dic_term_mul #(.COORD_WIDTH(COORD_WIDTH)) u_term_i (
        .clk   (clk),
        .ctl   (mul_ctl),
        .lift  (lift_i_reg),
        .minor (m3_reg),
        .term  (term_i)
    );

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            os4_reg <= os3_reg;
        end
        if (adv[5])
        begin
            os5_reg <= os4_reg;
        end
    end

    // Stage 6: the full determinant.
    logic signed [DET_W-1:0] det_reg;

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            det_reg <= DET_W'(term_c) + DET_W'(term_f) + DET_W'(term_i);
            os6_reg <= os5_reg;
        end
    end

    // Stage 7: output register.
    sign_t is_sign;
    logic  legal_reg;
    sign_t os_out_reg, is_out_reg;

    assign is_sign = sign_code(det_reg[DET_W-1], det_reg == '0);

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            os_out_reg <= os6_reg;
            is_out_reg <= is_sign;
            legal_reg  <= (os6_reg == SIGN_POS && is_sign == SIGN_NEG)
                       || (os6_reg == SIGN_NEG && is_sign == SIGN_POS);
        end
    end

    assign out_valid     = vld_reg[STAGES];
    assign edge_legal    = legal_reg;
    assign orient_sign   = os_out_reg;
    assign incircle_sign = is_out_reg;

endmodule

/* hw/rtl/dic_checker.sv */
module dic_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input logic           edge_legal,
    input dic_pkg::sign_t orient_sign,
    input dic_pkg::sign_t incircle_sign
);
    import dic_pkg::*;

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(edge_legal)
            && $stable(orient_sign) && $stable(incircle_sign))
        else $error("result beat changed while stalled");

    // The pipeline never blocks the input while the output drains.
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked while output is ready");

    a_sign_codes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (orient_sign == SIGN_ZERO || orient_sign == SIGN_POS
            || orient_sign == SIGN_NEG) && (incircle_sign == SIGN_ZERO
            || incircle_sign == SIGN_POS || incircle_sign == SIGN_NEG))
        else $error("sign field outside -1..1");

    // A legal edge needs two non-zero signs of opposite sense.
    a_legal_signs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && edge_legal |->
            (orient_sign == SIGN_POS && incircle_sign == SIGN_NEG)
            || (orient_sign == SIGN_NEG && incircle_sign == SIGN_POS))
        else $error("legal flag without opposite signs");

    a_illegal_signs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !edge_legal && orient_sign != SIGN_ZERO
            && incircle_sign != SIGN_ZERO |-> orient_sign == incircle_sign)
        else $error("legal flag clear with opposite signs");

endmodule

bind delaunay_incircle_legality_test dic_checker u_dic_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .edge_legal    (edge_legal),
    .orient_sign   (orient_sign),
    .incircle_sign (incircle_sign)
);

/* verif/legality_monitor.sv */
module legality_monitor #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] opp_x,
    input  logic signed [COORD_WIDTH-1:0] opp_y,
    input  logic signed [COORD_WIDTH-1:0] next_x,
    input  logic signed [COORD_WIDTH-1:0] next_y,
    input  logic signed [COORD_WIDTH-1:0] prev_x,
    input  logic signed [COORD_WIDTH-1:0] prev_y,
    input  logic signed [COORD_WIDTH-1:0] query_x,
    input  logic signed [COORD_WIDTH-1:0] query_y,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          edge_legal,
    input  dic_pkg::sign_t                orient_sign,
    input  dic_pkg::sign_t                incircle_sign,
    output int                            fail_count,
    output int                            pending
);

    import dic_pkg::*;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic  legal;
        sign_t orient;
        sign_t incircle;
    } verdict_t;

    verdict_t verdicts_due[$];
    int       result_beat;

    initial
    begin
        fail_count  = 0;
        pending     = 0;
        result_beat = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR result beat %0d: %s", result_beat, msg);
        fail_count++;
    endtask

    function automatic sign_t sign_of(input wide_t v);
        sign_t s;
        if (v < 0)
        begin
            s = SIGN_NEG;
        end
        else if (v == 0)
        begin
            s = SIGN_ZERO;
        end
        else
        begin
            s = SIGN_POS;
        end
        return s;
    endfunction

    function automatic verdict_t judge_edge(
        input coord_t ox, input coord_t oy,
        input coord_t nx, input coord_t ny,
        input coord_t px, input coord_t py,
        input coord_t qx, input coord_t qy
    );
        longint   nqx, nqy, oqx, oqy, pqx, pqy;
        longint   lift_n, lift_o, lift_p;
        longint   minor_op, minor_np, minor_no;
        longint   turn;
        wide_t    det;
        verdict_t v;
        nqx = longint'(nx) - longint'(qx);
        nqy = longint'(ny) - longint'(qy);
        oqx = longint'(ox) - longint'(qx);
        oqy = longint'(oy) - longint'(qy);
        pqx = longint'(px) - longint'(qx);
        pqy = longint'(py) - longint'(qy);
        lift_n = nqx * nqx + nqy * nqy;
        lift_o = oqx * oqx + oqy * oqy;
        lift_p = pqx * pqx + pqy * pqy;
        // Rows are taken in the order next, opp, prev, and the determinant
        // is expanded along the lifted column.
        minor_op = oqx * pqy - oqy * pqx;
        minor_np = nqx * pqy - nqy * pqx;
        minor_no = nqx * oqy - nqy * oqx;
        det = wide_t'(lift_n) * wide_t'(minor_op)
            - wide_t'(lift_o) * wide_t'(minor_np)
            + wide_t'(lift_p) * wide_t'(minor_no);
        turn = (longint'(ox) - longint'(nx)) * (longint'(py) - longint'(ny))
             - (longint'(oy) - longint'(ny)) * (longint'(px) - longint'(nx));
        v.orient   = sign_of(wide_t'(turn));
        v.incircle = sign_of(det);
        v.legal    = (turn < 0 && det > 0) || (turn > 0 && det < 0);
        return v;
    endfunction

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                verdicts_due.insert(verdicts_due.size(),
                                    judge_edge(opp_x, opp_y, next_x, next_y,
                                               prev_x, prev_y, query_x, query_y));
            end
            if (out_valid && out_ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    report_mismatch("result beat arrived with nothing expected");
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (edge_legal !== want.legal)
                    begin
                        report_mismatch($sformatf("edge_legal is %b, expected %b",
                                                  edge_legal, want.legal));
                    end
                    if (orient_sign !== want.orient)
                    begin
                        report_mismatch($sformatf("orient_sign is %0d, expected %0d",
                                                  orient_sign, want.orient));
                    end
                    if (incircle_sign !== want.incircle)
                    begin
                        report_mismatch($sformatf("incircle_sign is %0d, expected %0d",
                                                  incircle_sign, want.incircle));
                    end
                end
                result_beat++;
            end
        end
        pending <= verdicts_due.size();
    end

endmodule

/* verif/delaunay_incircle_legality_test_test.sv */
module delaunay_incircle_legality_test_test;

    import dic_pkg::*;

    localparam int CW         = 16;
    localparam int ITEMS      = 1450;
    localparam int QUIET_TAIL = 150;
    localparam int CMAX       = 32767;
    localparam int CMIN       = -32768;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct {
        coord_t ox, oy, nx, ny, px, py, qx, qy;
    } quad_t;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    coord_t opp_x, opp_y, next_x, next_y, prev_x, prev_y, query_x, query_y;
    logic   out_valid;
    logic   out_ready;
    logic   edge_legal;
    sign_t  orient_sign;
    sign_t  incircle_sign;
    int     fail_count;
    int     pending;
    bit     calm;
    bit     quiet;
    int     sent;
    int     stall_left;

    always #6 clk = ~clk;

    delaunay_incircle_legality_test #(
        .COORD_WIDTH(CW)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opp_x(opp_x),
        .opp_y(opp_y),
        .next_x(next_x),
        .next_y(next_y),
        .prev_x(prev_x),
        .prev_y(prev_y),
        .query_x(query_x),
        .query_y(query_y),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .edge_legal(edge_legal),
        .orient_sign(orient_sign),
        .incircle_sign(incircle_sign)
    );

    legality_monitor #(
        .COORD_WIDTH(CW)
    ) judge (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opp_x(opp_x),
        .opp_y(opp_y),
        .next_x(next_x),
        .next_y(next_y),
        .prev_x(prev_x),
        .prev_y(prev_y),
        .query_x(query_x),
        .query_y(query_y),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .edge_legal(edge_legal),
        .orient_sign(orient_sign),
        .incircle_sign(incircle_sign),
        .fail_count(fail_count),
        .pending(pending)
    );

    function automatic coord_t clamp_coord(input int v);
        coord_t c;
        if (v > CMAX)
        begin
            c = coord_t'(CMAX);
        end
        else if (v < CMIN)
        begin
            c = coord_t'(CMIN);
        end
        else
        begin
            c = coord_t'(v);
        end
        return c;
    endfunction

    function automatic quad_t mk(input int ox, input int oy, input int nx, input int ny,
                                 input int px, input int py, input int qx, input int qy);
        quad_t q;
        q.ox = clamp_coord(ox);
        q.oy = clamp_coord(oy);
        q.nx = clamp_coord(nx);
        q.ny = clamp_coord(ny);
        q.px = clamp_coord(px);
        q.py = clamp_coord(py);
        q.qx = clamp_coord(qx);
        q.qy = clamp_coord(qy);
        return q;
    endfunction

    // Integer points on a circle of radius five.
    function automatic void rim_point(input int idx, output int rx, output int ry);
        case (idx)
            0:       begin rx =  5; ry =  0; end
            1:       begin rx =  4; ry =  3; end
            2:       begin rx =  3; ry =  4; end
            3:       begin rx =  0; ry =  5; end
            4:       begin rx = -3; ry =  4; end
            5:       begin rx = -4; ry =  3; end
            6:       begin rx = -5; ry =  0; end
            7:       begin rx = -4; ry = -3; end
            8:       begin rx = -3; ry = -4; end
            9:       begin rx =  0; ry = -5; end
            10:      begin rx =  3; ry = -4; end
            default: begin rx =  4; ry = -3; end
        endcase
    endfunction

    function automatic int extreme_value();
        int v;
        case ($urandom_range(0, 6))
            0:       v = CMIN;
            1:       v = CMIN + 1;
            2:       v = -1;
            3:       v = 0;
            4:       v = 1;
            5:       v = CMAX - 1;
            default: v = CMAX;
        endcase
        return v;
    endfunction

    // Corner 0 is opp, 1 is next, 2 is prev and 3 is the query point.
    function automatic quad_t gen_quad();
        int kind, cx, cy, span, k, r, dx, dy, rx, ry;
        int x[4];
        int y[4];
        kind = $urandom_range(0, 99);
        for (int j = 0; j < 4; j++)
        begin
            if (kind < 30)
            begin
                x[j] = $urandom_range(0, 65535) + CMIN;
                y[j] = $urandom_range(0, 65535) + CMIN;
            end
            else if (kind >= 85)
            begin
                x[j] = extreme_value();
                y[j] = extreme_value();
            end
        end
        if (kind >= 30 && kind < 55)
        begin
            // A local cluster, mostly small, sometimes spanning the whole range.
            span = 1 << $urandom_range(1, 15);
            cx = $urandom_range(0, 65535) + CMIN;
            cy = $urandom_range(0, 65535) + CMIN;
            for (int j = 0; j < 4; j++)
            begin
                x[j] = cx + $urandom_range(0, 2 * span) - span;
                y[j] = cy + $urandom_range(0, 2 * span) - span;
            end
        end
        else if (kind >= 55 && kind < 75)
        begin
            // All four points on one circle, kept inside the range so that clamping never
            // moves one, so the incircle sign is zero; repeated points are allowed.
            k = $urandom_range(1, 6553);
            r = 5 * k;
            cx = $urandom_range(0, 2 * (CMAX - r)) - (CMAX - r);
            cy = $urandom_range(0, 2 * (CMAX - r)) - (CMAX - r);
            for (int j = 0; j < 4; j++)
            begin
                rim_point($urandom_range(0, 11), rx, ry);
                x[j] = cx + k * rx;
                y[j] = cy + k * ry;
            end
        end
        else if (kind >= 75 && kind < 85)
        begin
            // A flat triangle with the query point somewhere near it.
            dx = $urandom_range(0, 20) - 10;
            dy = $urandom_range(0, 20) - 10;
            cx = $urandom_range(0, 62000) - 31000;
            cy = $urandom_range(0, 62000) - 31000;
            for (int j = 0; j < 3; j++)
            begin
                k = $urandom_range(0, 200) - 100;
                x[j] = cx + k * dx;
                y[j] = cy + k * dy;
            end
            x[3] = cx + $urandom_range(0, 4000) - 2000;
            y[3] = cy + $urandom_range(0, 4000) - 2000;
        end
        return mk(x[0], y[0], x[1], y[1], x[2], y[2], x[3], y[3]);
    endfunction

    task automatic send_quad(input quad_t q);
        int gap;
        if (!quiet && !calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opp_x    <= q.ox;
        opp_y    <= q.oy;
        next_x   <= q.nx;
        next_y   <= q.ny;
        prev_x   <= q.px;
        prev_y   <= q.py;
        query_x  <= q.qx;
        query_y  <= q.qy;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!quiet && !calm && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 7);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        int n;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        out_ready  <= 1'b0;
        opp_x      <= '0;
        opp_y      <= '0;
        next_x     <= '0;
        next_y     <= '0;
        prev_x     <= '0;
        prev_y     <= '0;
        query_x    <= '0;
        query_y    <= '0;
        calm       <= 1'b0;
        quiet      <= 1'b0;
        stall_left = 0;
        sent       = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fully degenerate items and every field at its limits.
        send_quad(mk(0, 0, 0, 0, 0, 0, 0, 0));
        send_quad(mk(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
        send_quad(mk(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
        // Corners of the full square: cocircular at the largest scale, then with the query moved off the circle.
        send_quad(mk(CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX));
        send_quad(mk(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX));
        send_quad(mk(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX - 1));
        send_quad(mk(CMAX, CMAX, CMIN, CMAX, CMIN, CMIN, 0, 0));
        send_quad(mk(CMAX, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, CMIN + 1));
        // Anticlockwise and clockwise triangles, query inside and outside.
        send_quad(mk(0, 0, 100, 0, 0, 100, 1000, 1000));
        send_quad(mk(0, 0, 100, 0, 0, 100, 10, 10));
        send_quad(mk(0, 0, 0, 100, 100, 0, 10, 10));
        send_quad(mk(0, 0, 0, 100, 100, 0, -1000, 1000));
        // A right triangle has its far square corner on the circumcircle.
        send_quad(mk(0, 0, 100, 0, 0, 100, 100, 100));
        // Collinear corners, and a query point on a corner.
        send_quad(mk(0, 0, 5, 5, 10, 10, 3, 0));
        send_quad(mk(-7, 3, 20, 1, 4, 30, 20, 1));
        // A tiny triangle in one corner of the range, queried from the other.
        send_quad(mk(CMAX, CMAX, CMAX - 1, CMAX, CMAX, CMAX - 1, CMIN, CMIN));
        send_quad(mk(CMIN, CMIN, CMIN + 1, CMIN, CMIN, CMIN + 1, CMAX, CMAX));
        // Alternating bit patterns.
        send_quad(mk(21845, -21846, -21846, 21845, 21845, 21845, -21846, -21846));
        send_quad(mk(-21846, 21845, 21845, -21846, -21846, -21846, 21845, 21845));

        drain();

        n = 0;
        while (sent < ITEMS)
        begin
            if (n % 100 == 0)
            begin
                calm <= ($urandom_range(0, 3) == 0);
            end
            if (sent == ITEMS - QUIET_TAIL)
            begin
                quiet <= 1'b1;
            end
            if (n == 700)
            begin
                drain();
            end
            send_quad(gen_quad());
            n++;
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("delaunay_incircle_legality_test_test passed");
        end
        else
        begin
            $display("delaunay_incircle_legality_test_test failed");
        end
        $finish;
    end

    initial
    begin
        #5000000;
        $display("delaunay_incircle_legality_test_test failed");
        $finish;
    end

endmodule
